>>> hw/rtl/slsp_pkg.sv
package slsp_pkg;

  localparam int MaxItems      = 64;
  localparam int MaxCategories = 8;
  localparam int MaxClasses    = 32;
  localparam int MaxParams     = 64;
  localparam int AccDepth      = MaxItems * MaxCategories * MaxClasses;
  localparam int AccAw         = $clog2(AccDepth);
  localparam int ParAw         = $clog2(MaxParams);
  localparam logic [16:0] Log2eQ16 = 17'd94548;

  typedef enum logic [1:0] {
    REQ_LOAD  = 2'd0,
    REQ_DSGN  = 2'd1,
    REQ_READ  = 2'd2,
    REQ_NONE  = 2'd3
  } req_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_D_RD,
    ST_D_MUL,
    ST_D_WR,
    ST_G_RD,
    ST_G_CAP,
    ST_EXS,
    ST_EXW,
    ST_DVS,
    ST_DVW,
    ST_OUT
  } state_t;

  typedef logic [31:0] pow_tab_t [16];

  // integer square root, evaluated at elaboration only
  function automatic logic [63:0] isqrt64(input logic [63:0] x);
    logic [63:0] r;
    logic [63:0] b;
    logic [63:0] xx;
    r  = '0;
    b  = 64'd1 << 62;
    xx = x;
    for (int i = 0; i < 32; i++) begin
      if (xx >= r + b) begin
        xx = xx - (r + b);
        r  = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // 2^(-2^-(i+1)) in Q0.32
  function automatic pow_tab_t build_pow_tab();
    pow_tab_t t;
    logic [63:0] v;
    v    = isqrt64(64'd1 << 63);
    t[0] = v[31:0];
    for (int i = 1; i < 16; i++) begin
      v    = isqrt64({t[i-1], 32'd0});
      t[i] = v[31:0];
    end
    return t;
  endfunction

  localparam pow_tab_t PowTab = build_pow_tab();

endpackage

>>> hw/rtl/slsp_ram.sv
module slsp_ram #(
  parameter int W  = 32,
  parameter int D  = 1024,
  parameter int AW = $clog2(D)
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [W-1:0]  wdata,
  input  logic [AW-1:0] raddr,
  output logic [W-1:0]  rdata
);

  logic [W-1:0] mem [D];

  // write port
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

>>> hw/rtl/slsp_exp.sv
module slsp_exp
  import slsp_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [31:0] u,
  output logic        done,
  output logic [32:0] v
);

  logic        busy_r, busy_nxt;
  logic        scale_r, scale_nxt;
  logic [4:0]  step_r, step_nxt;
  logic [32:0] e_r, e_nxt;
  logic [32:0] m_r, m_nxt;
  logic        done_r, done_nxt;
  logic [32:0] v_r, v_nxt;
  logic [48:0] eprod;
  logic [64:0] mprod;
  logic [16:0] n_w;
  logic [3:0]  bi;

  assign eprod = {17'd0, u} * {32'd0, Log2eQ16};
  assign n_w   = e_r[32:16];
  assign bi    = step_r[3:0];
  assign mprod = m_r * {33'd0, PowTab[bi]};

  // scale to log2, then one fractional bit per cycle, then shift
  always_comb begin
    busy_nxt  = busy_r;
    scale_nxt = scale_r;
    step_nxt  = step_r;
    e_nxt     = e_r;
    m_nxt     = m_r;
    done_nxt  = 1'b0;
    v_nxt     = v_r;
    if (start) begin
      busy_nxt  = 1'b1;
      scale_nxt = 1'b1;
      step_nxt  = '0;
      m_nxt     = 33'h1_0000_0000;
      e_nxt     = eprod[48:16] + {32'd0, eprod[15]};
    end else if (busy_r) begin
      if (scale_r) begin
        scale_nxt = 1'b0;
      end else if (step_r == 5'd16) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
        v_nxt    = (n_w >= 17'd40) ? 33'd0 : (m_r >> n_w[5:0]);
      end else begin
        if (e_r[4'd15 - bi]) m_nxt = mprod[64:32];
        step_nxt = step_r + 5'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    scale_r <= scale_nxt;
    step_r  <= step_nxt;
    e_r     <= e_nxt;
    m_r     <= m_nxt;
    v_r     <= v_nxt;
  end

  assign done = done_r;
  assign v    = v_r;

endmodule

>>> hw/rtl/slsp_div.sv
module slsp_div (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [48:0] num,
  input  logic [35:0] den,
  output logic        done,
  output logic [15:0] q
);

  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic [4:0]  cnt_r, cnt_nxt;
  logic [36:0] rem_r, rem_nxt;
  logic [16:0] low_r, low_nxt;
  logic [16:0] quo_r, quo_nxt;
  logic [35:0] den_r, den_nxt;
  logic [36:0] trial;

  assign trial = {rem_r[35:0], low_r[16]};

  // restoring divide; the quotient fits 17 bits so the top starts as remainder
  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    low_nxt  = low_r;
    quo_nxt  = quo_r;
    den_nxt  = den_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      rem_nxt  = {5'd0, num[48:17]};
      low_nxt  = num[16:0];
      quo_nxt  = '0;
      den_nxt  = den;
    end else if (busy_r) begin
      low_nxt = {low_r[15:0], 1'b0};
      if (trial >= {1'b0, den_r}) begin
        rem_nxt = trial - {1'b0, den_r};
        quo_nxt = {quo_r[15:0], 1'b1};
      end else begin
        rem_nxt = trial;
        quo_nxt = {quo_r[15:0], 1'b0};
      end
      cnt_nxt = cnt_r + 5'd1;
      if (cnt_r == 5'd16) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    cnt_r <= cnt_nxt;
    rem_r <= rem_nxt;
    low_r <= low_nxt;
    quo_r <= quo_nxt;
    den_r <= den_nxt;
  end

  // saturate to Q0.16
  assign done = done_r;
  assign q    = quo_r[16] ? 16'hFFFF : quo_r[15:0];

endmodule

>>> hw/rtl/sparse_linear_softmax_probs_unit.sv
// Sparse linear predictor with per-group softmax.
// Input channel (in_valid / in_stall): one request per beat. A weight load
// is written in the accept cycle. A design entry reads its weight and
// accumulator, then multiplies, rounds, saturates and writes back.
// A group read takes the accumulators of K categories (K from cfg_wdata,
// 0 acts as 1, above 8 as 8) of one item and class and returns K result
// beats on the output channel in category order, out_last on the final one.
// The accumulators read are cleared as each result is produced.
// A group read first reads the K accumulators, then runs the exp unit once
// per category (one bit of the fractional power per cycle), then the serial
// divider once per category, each quotient followed by its result beat.
// Requests are handled one at a time; in_stall is high while one is at work.
// If the receiver stalls, the result beat holds and the block waits.
// After reset the accumulator memory is swept to zero, one entry per cycle,
// with in_stall high; cfg writes are taken at any time.
// Weight entries are undefined until loaded.
module sparse_linear_softmax_probs_unit
  import slsp_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         in_req_type,
  input  logic [5:0]         in_item,
  input  logic [2:0]         in_category,
  input  logic [4:0]         in_class_idx,
  input  logic [5:0]         in_param_idx,
  input  logic signed [15:0] in_design_value,
  input  logic signed [23:0] in_lambda_value,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [5:0]         out_item,
  output logic [2:0]         out_category,
  output logic [4:0]         out_class,
  output logic [15:0]        out_prob,
  output logic               out_last,
  input  logic               cfg_we,
  input  logic [3:0]         cfg_wdata
);

  state_t state_r, state_nxt;

  logic [3:0]         ncat_r;
  logic [3:0]         kn_r, kn_nxt;
  logic [AccAw-1:0]   clr_r, clr_nxt;
  logic [5:0]         item_r, item_nxt;
  logic [2:0]         cat_r, cat_nxt;
  logic [4:0]         cls_r, cls_nxt;
  logic [ParAw-1:0]   par_r, par_nxt;
  logic signed [15:0] dv_r, dv_nxt;
  logic signed [39:0] prod_r, prod_nxt;
  logic signed [31:0] acc_r, acc_nxt;
  logic [2:0]         cnt_r, cnt_nxt;
  logic signed [31:0] a_r [MaxCategories];
  logic signed [31:0] mx_r, mx_nxt;
  logic [32:0]        v_r [MaxCategories];
  logic [35:0]        sum_r, sum_nxt;
  logic               ov_r, ov_nxt;
  logic [15:0]        prob_r, prob_nxt;
  logic               a_we, v_we;

  logic               w_we;
  logic [23:0]        w_rdata;
  logic               acc_we;
  logic [AccAw-1:0]   acc_waddr, acc_raddr;
  logic [31:0]        acc_wdata, acc_rdata;

  logic               exp_start, exp_done, div_start, div_done;
  logic [32:0]        exp_v;
  logic [15:0]        div_q;
  logic signed [32:0] diff;
  logic signed [40:0] rnd;
  logic signed [28:0] qd;
  logic signed [33:0] ssum;
  logic signed [31:0] sat;
  logic [3:0]         kn_in;
  logic               acc_out, last_w;

  assign acc_out = ov_r && !out_stall;
  assign last_w  = ({1'b0, cnt_r} + 4'd1) == kn_r;

  // clamp the category count
  assign kn_in = (ncat_r == 4'd0) ? 4'd1 :
                 (ncat_r > 4'(MaxCategories)) ? 4'(MaxCategories) : ncat_r;

  // design term: round to Q16.16 and saturate the sum
  assign rnd  = {prod_r[39], prod_r} + 41'sd2048;
  assign qd   = rnd[40:12];
  assign ssum = {{2{acc_r[31]}}, acc_r} + {{5{qd[28]}}, qd};
  assign sat  = (ssum > 34'sh0_7FFF_FFFF) ? 32'sh7FFF_FFFF :
                (ssum < -34'sh0_8000_0000) ? 32'sh8000_0000 : ssum[31:0];

  assign diff = {mx_r[31], mx_r} - {a_r[cnt_r][31], a_r[cnt_r]};

  slsp_ram #(.W(24), .D(MaxParams)) u_wram (
    .clk  (clk),
    .we   (w_we),
    .waddr(in_param_idx),
    .wdata(in_lambda_value),
    .raddr(par_r),
    .rdata(w_rdata)
  );

  slsp_ram #(.W(32), .D(AccDepth)) u_aram (
    .clk  (clk),
    .we   (acc_we),
    .waddr(acc_waddr),
    .wdata(acc_wdata),
    .raddr(acc_raddr),
    .rdata(acc_rdata)
  );

  slsp_exp u_exp (
    .clk  (clk),
    .rst_n(rst_n),
    .start(exp_start),
    .u    (diff[31:0]),
    .done (exp_done),
    .v    (exp_v)
  );

  slsp_div u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .start(div_start),
    .num  ({v_r[cnt_r], 16'd0} + {14'd0, sum_r[35:1]}),
    .den  (sum_r),
    .done (div_done),
    .q    (div_q)
  );

  // sequencer
  always_comb begin
    state_nxt = state_r;
    kn_nxt    = kn_r;
    clr_nxt   = clr_r;
    item_nxt  = item_r;
    cat_nxt   = cat_r;
    cls_nxt   = cls_r;
    par_nxt   = par_r;
    dv_nxt    = dv_r;
    prod_nxt  = prod_r;
    acc_nxt   = acc_r;
    cnt_nxt   = cnt_r;
    mx_nxt    = mx_r;
    sum_nxt   = sum_r;
    ov_nxt    = ov_r;
    prob_nxt  = prob_r;
    a_we      = 1'b0;
    v_we      = 1'b0;
    w_we      = 1'b0;
    acc_we    = 1'b0;
    acc_waddr = {item_r, cnt_r, cls_r};
    acc_wdata = '0;
    acc_raddr = {item_r, cnt_r, cls_r};
    exp_start = 1'b0;
    div_start = 1'b0;
    in_stall  = 1'b1;
    unique case (state_r)
      ST_CLEAR: begin
        acc_we    = 1'b1;
        acc_waddr = clr_r;
        clr_nxt   = clr_r + 1'b1;
        if (&clr_r) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          item_nxt = in_item;
          cat_nxt  = in_category;
          cls_nxt  = in_class_idx;
          par_nxt  = in_param_idx;
          dv_nxt   = in_design_value;
          kn_nxt   = kn_in;
          cnt_nxt  = '0;
          sum_nxt  = '0;
          unique case (in_req_type)
            REQ_LOAD: w_we = 1'b1;
            REQ_DSGN: state_nxt = ST_D_RD;
            REQ_READ: state_nxt = ST_G_RD;
            default: ;
          endcase
        end
      end
      ST_D_RD: begin
        acc_raddr = {item_r, cat_r, cls_r};
        state_nxt = ST_D_MUL;
      end
      ST_D_MUL: begin
        prod_nxt  = dv_r * $signed(w_rdata);
        acc_nxt   = acc_rdata;
        state_nxt = ST_D_WR;
      end
      ST_D_WR: begin
        acc_we    = 1'b1;
        acc_waddr = {item_r, cat_r, cls_r};
        acc_wdata = sat;
        state_nxt = ST_IDLE;
      end
      ST_G_RD: begin
        state_nxt = ST_G_CAP;
      end
      ST_G_CAP: begin
        a_we = 1'b1;
        if (cnt_r == 3'd0 || $signed(acc_rdata) > mx_r) mx_nxt = acc_rdata;
        if (last_w) begin
          cnt_nxt   = '0;
          state_nxt = ST_EXS;
        end else begin
          cnt_nxt   = cnt_r + 3'd1;
          state_nxt = ST_G_RD;
        end
      end
      ST_EXS: begin
        exp_start = 1'b1;
        state_nxt = ST_EXW;
      end
      ST_EXW: begin
        if (exp_done) begin
          v_we    = 1'b1;
          sum_nxt = sum_r + {3'd0, exp_v};
          if (last_w) begin
            cnt_nxt   = '0;
            state_nxt = ST_DVS;
          end else begin
            cnt_nxt   = cnt_r + 3'd1;
            state_nxt = ST_EXS;
          end
        end
      end
      ST_DVS: begin
        div_start = 1'b1;
        state_nxt = ST_DVW;
      end
      ST_DVW: begin
        if (div_done) begin
          acc_we    = 1'b1;
          prob_nxt  = div_q;
          ov_nxt    = 1'b1;
          state_nxt = ST_OUT;
        end
      end
      ST_OUT: begin
        if (acc_out) begin
          ov_nxt = 1'b0;
          if (last_w) begin
            state_nxt = ST_IDLE;
          end else begin
            cnt_nxt   = cnt_r + 3'd1;
            state_nxt = ST_DVS;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
      clr_r   <= '0;
      ov_r    <= 1'b0;
      ncat_r  <= 4'd8;
    end else begin
      state_r <= state_nxt;
      clr_r   <= clr_nxt;
      ov_r    <= ov_nxt;
      if (cfg_we) ncat_r <= cfg_wdata;
    end
    kn_r   <= kn_nxt;
    item_r <= item_nxt;
    cat_r  <= cat_nxt;
    cls_r  <= cls_nxt;
    par_r  <= par_nxt;
    dv_r   <= dv_nxt;
    prod_r <= prod_nxt;
    acc_r  <= acc_nxt;
    cnt_r  <= cnt_nxt;
    mx_r   <= mx_nxt;
    sum_r  <= sum_nxt;
    prob_r <= prob_nxt;
    if (a_we) a_r[cnt_r] <= acc_rdata;
    if (v_we) v_r[cnt_r] <= exp_v;
  end

  assign out_valid    = ov_r;
  assign out_item     = item_r;
  assign out_category = cnt_r;
  assign out_class    = cls_r;
  assign out_prob     = prob_r;
  assign out_last     = last_w;

  // a result beat is only offered while the sequencer waits on it
  a_ov_state: assert property (@(posedge clk) disable iff (!rst_n)
    ov_r |-> state_r == ST_OUT)
    else $error("result valid outside output state");

  // the exp and divide units never finish together
  a_units: assert property (@(posedge clk) disable iff (!rst_n)
    !(exp_done && div_done))
    else $error("exp and divide overlap");

  // a taken final beat returns the block to idle
  a_last: assert property (@(posedge clk) disable iff (!rst_n)
    (acc_out && last_w) |=> state_r == ST_IDLE)
    else $error("group did not end on last beat");

endmodule

>>> sim/sparse_linear_softmax_probs_unit_tb.sv
module sparse_linear_softmax_probs_unit_tb;
  import slsp_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    req_t             kind;
    logic [5:0]       item;
    logic [2:0]       cat;
    logic [4:0]       cls;
    logic [5:0]       par;
    logic signed [15:0] dval;
    logic signed [23:0] lval;
  } request_t;

  typedef struct {
    logic [5:0]  item;
    logic [2:0]  cat;
    logic [4:0]  cls;
    logic [15:0] prob;
    logic        last;
  } prob_beat_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [1:0]         in_req_type = REQ_NONE;
  logic [5:0]         in_item = '0;
  logic [2:0]         in_category = '0;
  logic [4:0]         in_class_idx = '0;
  logic [5:0]         in_param_idx = '0;
  logic signed [15:0] in_design_value = '0;
  logic signed [23:0] in_lambda_value = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [5:0]         out_item;
  logic [2:0]         out_category;
  logic [4:0]         out_class;
  logic [15:0]        out_prob;
  logic               out_last;
  logic               cfg_we = 1'b0;
  logic [3:0]         cfg_wdata = '0;

  // Shadow state of the block
  logic signed [23:0] weight_mem [MaxParams];
  logic signed [31:0] lin_acc [MaxItems][MaxCategories][MaxClasses];
  logic [3:0]         cat_count = 4'd8;
  longint unsigned    frac_pow [16];

  request_t   pend_q [$];
  prob_beat_t prob_q [$];
  bit         weight_set [MaxParams];
  int         errors = 0;
  int         send_idle = 18;
  int         recv_idle = 76;
  int         phase = 0;
  int         quiet_cycles = 0;
  int         hold_cnt = 0;
  bit         hold_done = 1'b0;
  logic       in_taken = 1'b0;

  sparse_linear_softmax_probs_unit uut (.*);

  always #6 clk = ~clk;

  function automatic longint unsigned root64(longint unsigned x);
    longint unsigned r, c;
    r = 0;
    for (int b = 31; b >= 0; b--) begin
      c = r | (64'd1 << b);
      if (c * c <= x) r = c;
    end
    return r;
  endfunction

  // 2^(-u*log2e) in Q0.32
  function automatic longint unsigned neg_exp(longint unsigned u);
    longint unsigned e, n, f, m;
    e = (u * 94548 + 32768) >> 16;
    n = e >> 16;
    f = e & 64'hFFFF;
    m = 64'd1 << 32;
    if (n >= 40) return 0;
    for (int i = 0; i < 16; i++)
      if (f[15-i]) m = (m * frac_pow[i]) >> 32;
    return m >> n;
  endfunction

  // Apply one accepted request to the shadow state
  task automatic apply_request(request_t rq);
    longint signed   p, s;
    longint unsigned v [8];
    longint unsigned sum, pr;
    int              kn;
    logic signed [31:0] mx;
    prob_beat_t      bt;
    case (rq.kind)
      REQ_LOAD: weight_mem[rq.par] = rq.lval;
      REQ_DSGN: begin
        p = longint'(rq.dval) * longint'(weight_mem[rq.par]);
        p = (p + 2048) >>> 12;
        s = longint'(lin_acc[rq.item][rq.cat][rq.cls]) + p;
        if (s > 64'sd2147483647) s = 64'sd2147483647;
        if (s < -64'sd2147483648) s = -64'sd2147483648;
        lin_acc[rq.item][rq.cat][rq.cls] = s[31:0];
      end
      REQ_READ: begin
        kn = (cat_count == 4'd0) ? 1 :
             (int'(cat_count) > MaxCategories) ? MaxCategories : int'(cat_count);
        mx = lin_acc[rq.item][0][rq.cls];
        for (int k = 1; k < kn; k++)
          if (lin_acc[rq.item][k][rq.cls] > mx) mx = lin_acc[rq.item][k][rq.cls];
        sum = 0;
        for (int k = 0; k < kn; k++) begin
          v[k] = neg_exp(longint'(mx) - longint'(lin_acc[rq.item][k][rq.cls]));
          sum += v[k];
        end
        for (int k = 0; k < kn; k++) begin
          pr = ((v[k] << 16) + (sum >> 1)) / sum;
          bt.item = rq.item;
          bt.cat  = 3'(k);
          bt.cls  = rq.cls;
          bt.prob = (pr > 65535) ? 16'hFFFF : pr[15:0];
          bt.last = (k == kn - 1);
          prob_q.push_back(bt);
          lin_acc[rq.item][k][rq.cls] = '0;
        end
      end
      default: ;
    endcase
  endtask

  // Queue one request, tracking which weights have been loaded
  task automatic push_req(req_t kind, int item, int cat, int cls, int par,
                          int dval, int lval);
    request_t rq;
    rq.kind = kind;
    rq.item = 6'(item);
    rq.cat  = 3'(cat);
    rq.cls  = 5'(cls);
    rq.par  = 6'(par);
    rq.dval = 16'(dval);
    rq.lval = 24'(lval);
    if (kind == REQ_LOAD) weight_set[par] = 1'b1;
    pend_q.push_back(rq);
  endtask

  function automatic int loaded_param();
    int p;
    do p = $urandom_range(63); while (!weight_set[p]);
    return p;
  endfunction

  // Well-formed group: a few design entries, then a read; some noise
  task automatic gen_random(int count);
    int n, it, cl, len, p;
    n = 0;
    while (n < count) begin
      if ($urandom_range(99) < 15) begin
        p = $urandom_range(3);
        if (p == REQ_DSGN) begin
          push_req(REQ_DSGN, $urandom_range(63), $urandom_range(7), $urandom_range(31),
                   loaded_param(), $urandom, 0);
        end else begin
          push_req(req_t'(p), $urandom_range(63), $urandom_range(7), $urandom_range(31),
                   $urandom_range(63), $urandom, $urandom);
        end
        n++;
      end else begin
        it = ($urandom_range(3) == 0) ? $urandom_range(63) : $urandom_range(2);
        cl = ($urandom_range(3) == 0) ? $urandom_range(31) : $urandom_range(1);
        if ($urandom_range(4) == 0) begin
          push_req(REQ_LOAD, 0, 0, 0, $urandom_range(63), 0, $urandom);
          n++;
        end
        if ($urandom_range(19) == 0) begin
          // drive one cell toward saturation
          push_req(REQ_LOAD, 0, 0, 0, 5, 0, $urandom_range(1) ? 8388607 : -8388608);
          len = 40;
          for (int i = 0; i < len; i++)
            push_req(REQ_DSGN, it, 0, cl, 5, 32767, 0);
          n += len + 1;
        end else begin
          len = $urandom_range(1, 6);
          for (int i = 0; i < len; i++)
            push_req(REQ_DSGN, it, $urandom_range(7), cl, loaded_param(), $urandom, 0);
          n += len;
        end
        push_req(REQ_READ, it, $urandom_range(7), cl, $urandom_range(63), $urandom, 0);
        n++;
      end
    end
  endtask

  // Hold off until the block has drained everything
  task automatic drain();
    while (pend_q.size() != 0 || in_valid || prob_q.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  task automatic write_count(logic [3:0] k);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= k;
    cat_count = k;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Sample both channels; predict on input beats, check result beats
  always @(posedge clk) begin
    prob_beat_t want;
    in_taken <= in_valid && !in_stall;
    if (rst_n) begin
      if (in_valid && !in_stall)
        apply_request('{req_t'(in_req_type), in_item, in_category, in_class_idx,
                        in_param_idx, in_design_value, in_lambda_value});
      if (out_valid && !out_stall) begin
        if (prob_q.size() == 0) begin
          $display("%0t: unexpected beat item %0d cat %0d class %0d prob %0d", $time,
                   out_item, out_category, out_class, out_prob);
          errors++;
        end else begin
          want = prob_q.pop_front();
          if (out_item !== want.item || out_category !== want.cat ||
              out_class !== want.cls || out_prob !== want.prob || out_last !== want.last) begin
            $display("%0t: mismatch expected item %0d cat %0d class %0d prob %0d last %0d,",
                     $time, want.item, want.cat, want.cls, want.prob, want.last);
            $display("%0t:          actual   item %0d cat %0d class %0d prob %0d last %0d",
                     $time, out_item, out_category, out_class, out_prob, out_last);
            errors++;
          end
        end
      end
      // watchdog on cycles with no beat on either channel
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= 60000) begin
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  // Feed the input channel; hold the payload while stalled
  always @(negedge clk) begin
    request_t rq;
    if (rst_n && !(in_valid && !in_taken)) begin
      if (pend_q.size() != 0 && $urandom_range(99) >= send_idle) begin
        rq = pend_q.pop_front();
        in_req_type     <= rq.kind;
        in_item         <= rq.item;
        in_category     <= rq.cat;
        in_class_idx    <= rq.cls;
        in_param_idx    <= rq.par;
        in_design_value <= rq.dval;
        in_lambda_value <= rq.lval;
        in_valid        <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: random stalls, one long hold-off at the start of the last phase
  always @(negedge clk) begin
    if (phase == 3 && !hold_done) begin
      out_stall <= 1'b1;
      hold_cnt++;
      if (hold_cnt == 800) hold_done = 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle);
    end
  end

  initial begin
    frac_pow[0] = root64(64'd1 << 63);
    for (int i = 1; i < 16; i++) frac_pow[i] = root64(frac_pow[i-1] << 32);
    for (int i = 0; i < MaxParams; i++) begin
      weight_mem[i] = '0;
      weight_set[i] = 1'b0;
    end
    foreach (lin_acc[a, b, c]) lin_acc[a][b][c] = '0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    write_count(4'd8);

    // Directed: extreme weights and values, empty group, unused type
    push_req(REQ_LOAD, 0, 0, 0, 0, 0, 8388607);
    push_req(REQ_LOAD, 0, 0, 0, 63, 0, -8388608);
    push_req(REQ_LOAD, 0, 0, 0, 1, 0, 65536);
    push_req(REQ_LOAD, 0, 0, 0, 2, 0, 0);
    push_req(REQ_DSGN, 63, 7, 31, 0, 32767, 0);
    push_req(REQ_DSGN, 63, 0, 31, 63, -32768, 0);
    push_req(REQ_DSGN, 63, 3, 31, 1, 4096, 0);
    push_req(REQ_DSGN, 63, 5, 31, 2, -1, 0);
    push_req(REQ_READ, 63, 0, 31, 0, 0, 0);
    push_req(REQ_READ, 0, 0, 0, 0, 0, 0);
    push_req(REQ_NONE, 63, 7, 31, 63, -1, -1);
    push_req(REQ_DSGN, 0, 1, 0, 1, -32768, 0);
    push_req(REQ_DSGN, 0, 6, 0, 0, 32767, 0);
    push_req(REQ_READ, 0, 7, 0, 63, 0, 0);
    drain();

    // Single category: full share saturates; category beyond K kept
    write_count(4'd1);
    push_req(REQ_DSGN, 10, 0, 3, 1, 8192, 0);
    push_req(REQ_DSGN, 10, 2, 3, 1, 8192, 0);
    push_req(REQ_READ, 10, 0, 3, 0, 0, 0);
    drain();
    write_count(4'd0);
    push_req(REQ_READ, 10, 0, 3, 0, 0, 0);
    drain();
    write_count(4'd15);
    push_req(REQ_READ, 10, 0, 3, 0, 0, 0);
    drain();

    // Random phases
    write_count(4'd3);
    phase = 1;
    gen_random(45);
    drain();
    gen_random(45);
    drain();
    write_count(4'd8);
    send_idle = 76;
    recv_idle = 18;
    phase = 2;
    gen_random(85);
    drain();
    write_count(4'd5);
    send_idle = 0;
    recv_idle = 0;
    gen_random(85);
    phase = 3;
    drain();
    repeat (50) @(posedge clk);
    if (errors == 0 && prob_q.size() == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

endmodule
